// ----- rtl/core/lwqd_pkg.sv -----
// Shared types and constants of the least-work queue dispatcher.
// Used by the core and its checker; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package lwqd_pkg;

	localparam int LINE_COUNT = 3;
	localparam int LINE_IDX_W = 2;
	localparam int TAG_W      = 8;
	localparam int SVC_W      = 8;

	// stream widths
	localparam int S_TDATA_W = 16;
	localparam int M_TDATA_W = 32;

	// result layout, lowest bit up
	localparam int ASSIGN_POS   = 0;
	localparam int DROP_POS     = 2;
	localparam int LINE_REC_POS = 3;
	localparam int LINE_REC_W   = 9;
	localparam int RES_W        = LINE_REC_POS + LINE_COUNT * LINE_REC_W;

	// one queued job: tag and remaining service
	typedef struct packed {
		logic [TAG_W-1:0] tag;
		logic [SVC_W-1:0] rem;
	} job_t;

	localparam int JOB_W = TAG_W + SVC_W;

endpackage
`default_nettype wire

// ----- rtl/core/lwqd_ram.sv -----
// Generic single write, single read RAM with registered, read-first output.
// Stand-alone; no package needed.
`timescale 1ns / 1ps
`default_nettype none
module lwqd_ram #(
	parameter int DATA_W = 16,
	parameter int DEPTH  = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [DATA_W-1:0]        wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [DATA_W-1:0]        rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ----- rtl/core/least_work_queue_dispatcher_core.sv -----
// Least-work dispatcher over three service lines: state, per-line queues and result buffer.
// Depends on lwqd_pkg and lwqd_ram (one ring RAM per line).
// An accepted tick's result is registered in out_q, or in skid_q while the output stalls.
// Throughput: one tick per cycle unless stalled; every line update is one pass of short logic.
// Output stall: a skid entry holds one more result; input stalls only when both are full.
// Reset: asynchronous, active low; all lines empty, work sums zero, no results pending.
`timescale 1ns / 1ps
`default_nettype none
module least_work_queue_dispatcher_core #(
	parameter int LINE_DEPTH = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// input ticks
	input  wire logic                           s_axis_tvalid,
	output      logic                           s_axis_tready,
	input  wire logic [lwqd_pkg::S_TDATA_W-1:0] s_axis_tdata,  // job_tag[7:0], service_time[15:8]
	input  wire logic                           s_axis_tuser,  // arrival
	// results
	output      logic                           m_axis_tvalid,
	input  wire logic                           m_axis_tready,
	output      logic [lwqd_pkg::M_TDATA_W-1:0] m_axis_tdata   // assigned_line[1:0],
	                                                           // arrival_dropped[2],
	                                                           // line1_done[3], line1_tag[11:4],
	                                                           // line2_done[12], line2_tag[20:13],
	                                                           // line3_done[21], line3_tag[29:22],
	                                                           // zero[31:30]
);

	localparam int PTR_W  = $clog2(LINE_DEPTH);
	localparam int FILL_W = $clog2(LINE_DEPTH + 1);
	localparam int WORK_W = $clog2(LINE_DEPTH * 255 + 1);
	localparam int LC     = lwqd_pkg::LINE_COUNT;

	// Each line keeps its head job in registers (serviced every tick) and the
	// jobs behind it in a ring RAM. The RAM read port always points at the job
	// right behind the head; a registered bypass covers a write to that slot.

	logic                               acc;
	logic                               arrival;
	logic [lwqd_pkg::TAG_W-1:0]         in_tag;
	logic [lwqd_pkg::SVC_W-1:0]         in_svc;
	logic [lwqd_pkg::SVC_W-1:0]         svc_eff;

	logic [FILL_W-1:0]                  fill_q     [LC];
	logic [WORK_W-1:0]                  work_q     [LC];
	logic [PTR_W-1:0]                   rd_ptr_q   [LC];
	logic [PTR_W-1:0]                   wr_ptr_q   [LC];
	lwqd_pkg::job_t                     head_q     [LC];
	logic                               byp_q      [LC];
	lwqd_pkg::job_t                     byp_data_q [LC];

	logic [LC-1:0]                      line_full;
	logic [LC-1:0]                      line_done;
	logic [lwqd_pkg::TAG_W-1:0]         done_tag   [LC];
	logic [lwqd_pkg::LINE_IDX_W-1:0]    pick;
	logic                               dropped;
	logic [lwqd_pkg::M_TDATA_W-1:0]     res;

	logic                               out_v_q;
	logic [lwqd_pkg::M_TDATA_W-1:0]     out_q;
	logic                               skid_v_q;
	logic [lwqd_pkg::M_TDATA_W-1:0]     skid_q;

	assign s_axis_tready = !skid_v_q;
	assign acc           = s_axis_tvalid && s_axis_tready;
	assign arrival       = s_axis_tuser;
	assign in_tag        = s_axis_tdata[lwqd_pkg::TAG_W-1:0];
	assign in_svc        = s_axis_tdata[lwqd_pkg::TAG_W +: lwqd_pkg::SVC_W];
	// a zero service time would never finish; serve it as one tick
	assign svc_eff       = (in_svc == '0) ? lwqd_pkg::SVC_W'(1) : in_svc;

	// least remaining work, ties to the lower line
	always_comb begin
		logic [WORK_W-1:0] best_w;
		pick   = '0;
		best_w = work_q[0];
		if (work_q[1] < best_w) begin
			pick   = lwqd_pkg::LINE_IDX_W'(1);
			best_w = work_q[1];
		end
		if (work_q[2] < best_w) begin
			pick = lwqd_pkg::LINE_IDX_W'(2);
		end
	end

	// full chosen line: arrival lost, no other line tried
	assign dropped = arrival && line_full[pick];

	for (genvar k = 0; k < LC; k++) begin : g_line
		logic                    here;
		logic                    serviced;
		lwqd_pkg::job_t          cur;
		lwqd_pkg::job_t          next_job;
		lwqd_pkg::job_t          rdata;
		logic [2*lwqd_pkg::SVC_W-1:0] rdata_raw;
		logic                    ram_we;
		logic [PTR_W-1:0]        rd_ptr_d;

		assign line_full[k] = (fill_q[k] >= FILL_W'(LINE_DEPTH));
		assign here         = arrival && (pick == lwqd_pkg::LINE_IDX_W'(k)) && !line_full[k];
		// arrival is queued before service, so it is the head of an empty line
		assign serviced     = (fill_q[k] != '0) || here;
		assign cur          = (fill_q[k] == '0) ? lwqd_pkg::job_t'{tag: in_tag, rem: svc_eff}
		                                        : head_q[k];
		assign line_done[k] = serviced && (cur.rem == lwqd_pkg::SVC_W'(1));
		assign done_tag[k]  = line_done[k] ? cur.tag : '0;

		assign rdata    = lwqd_pkg::job_t'(rdata_raw);
		assign next_job = byp_q[k] ? byp_data_q[k] : rdata;

		// a job that follows a lone head which leaves now goes straight to the head
		assign ram_we   = acc && here && (fill_q[k] != '0)
		                  && !((fill_q[k] == FILL_W'(1)) && line_done[k]);
		assign rd_ptr_d = (acc && line_done[k] && (fill_q[k] > FILL_W'(1)))
		                  ? ((rd_ptr_q[k] == PTR_W'(LINE_DEPTH - 1)) ? '0 : rd_ptr_q[k] + 1'b1)
		                  : rd_ptr_q[k];

		lwqd_ram #(
			.DATA_W (lwqd_pkg::JOB_W),
			.DEPTH  (LINE_DEPTH)
		) u_ram (
			.clk   (clk),
			.we    (ram_we),
			.waddr (wr_ptr_q[k]),
			.wdata (lwqd_pkg::job_t'{tag: in_tag, rem: svc_eff}),
			.raddr (rd_ptr_d),
			.rdata (rdata_raw)
		);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				fill_q[k]   <= '0;
				work_q[k]   <= '0;
				rd_ptr_q[k] <= '0;
				wr_ptr_q[k] <= '0;
				byp_q[k]    <= 1'b0;
			end else begin
				byp_q[k]    <= ram_we && (wr_ptr_q[k] == rd_ptr_d);
				rd_ptr_q[k] <= rd_ptr_d;
				if (ram_we) begin
					wr_ptr_q[k] <= (wr_ptr_q[k] == PTR_W'(LINE_DEPTH - 1)) ? '0
					               : wr_ptr_q[k] + 1'b1;
				end
				if (acc) begin
					fill_q[k] <= fill_q[k] + FILL_W'(here) - FILL_W'(line_done[k]);
					work_q[k] <= work_q[k] + (here ? WORK_W'(svc_eff) : '0)
					             - WORK_W'(serviced);
				end
			end
		end

		always_ff @(posedge clk) begin
			if (ram_we) begin
				byp_data_q[k] <= lwqd_pkg::job_t'{tag: in_tag, rem: svc_eff};
			end
			if (acc) begin
				if (line_done[k]) begin
					if (fill_q[k] > FILL_W'(1)) begin
						head_q[k] <= next_job;
					end else begin
						head_q[k] <= lwqd_pkg::job_t'{tag: in_tag, rem: svc_eff};
					end
				end else if (serviced) begin
					head_q[k] <= lwqd_pkg::job_t'{tag: cur.tag,
					                              rem: cur.rem - lwqd_pkg::SVC_W'(1)};
				end
			end
		end
	end

	// pack the result
	always_comb begin
		res = '0;
		res[lwqd_pkg::ASSIGN_POS +: lwqd_pkg::LINE_IDX_W] =
			arrival ? pick + lwqd_pkg::LINE_IDX_W'(1) : '0;
		res[lwqd_pkg::DROP_POS] = dropped;
		for (int k = 0; k < LC; k++) begin
			res[lwqd_pkg::LINE_REC_POS + k * lwqd_pkg::LINE_REC_W] = line_done[k];
			res[lwqd_pkg::LINE_REC_POS + k * lwqd_pkg::LINE_REC_W + 1 +: lwqd_pkg::TAG_W] =
				done_tag[k];
		end
	end

	// output register plus skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (m_axis_tready || !out_v_q) begin
				out_v_q  <= skid_v_q || acc;
				skid_v_q <= 1'b0;
			end else if (acc) begin
				skid_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (m_axis_tready || !out_v_q) begin
			out_q <= skid_v_q ? skid_q : res;
		end else if (acc) begin
			skid_q <= res;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = out_q;

endmodule
`default_nettype wire

// ----- rtl/core/lwqd_checker.sv -----
// Port-level checks of the dispatcher core, bound to every instance.
// Depends on lwqd_pkg for the result layout.
`timescale 1ns / 1ps
`default_nettype none
module lwqd_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           s_axis_tvalid,
	input wire logic                           s_axis_tready,
	input wire logic                           m_axis_tvalid,
	input wire logic                           m_axis_tready,
	input wire logic [lwqd_pkg::M_TDATA_W-1:0] m_axis_tdata
);

	localparam int R0 = lwqd_pkg::LINE_REC_POS;
	localparam int R1 = R0 + lwqd_pkg::LINE_REC_W;
	localparam int R2 = R1 + lwqd_pkg::LINE_REC_W;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	a_tag_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |->
			(m_axis_tdata[R0] || m_axis_tdata[R0+1 +: lwqd_pkg::TAG_W] == '0) &&
			(m_axis_tdata[R1] || m_axis_tdata[R1+1 +: lwqd_pkg::TAG_W] == '0) &&
			(m_axis_tdata[R2] || m_axis_tdata[R2+1 +: lwqd_pkg::TAG_W] == '0))
		else $error("departure tag without departure");

	a_drop_line: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[lwqd_pkg::DROP_POS] |->
			m_axis_tdata[lwqd_pkg::ASSIGN_POS +: lwqd_pkg::LINE_IDX_W] != '0)
		else $error("drop reported without a chosen line");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("input stalled with no result pending");

	a_result_next: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> m_axis_tvalid)
		else $error("accepted tick gave no result");

endmodule

bind least_work_queue_dispatcher_core lwqd_checker u_lwqd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

// ----- dv/lwqd_checker.sv -----
// Scoreboard for the least-work queue dispatcher: watches both stream ports,
// predicts each tick's result and compares it field by field. Depends on lwqd_pkg.
`timescale 1ns / 1ps
module lwqd_scoreboard #(
	parameter int LINE_DEPTH = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_axis_tvalid,
	input  wire logic                           s_axis_tready,
	input  wire logic [lwqd_pkg::S_TDATA_W-1:0] s_axis_tdata,  // job_tag[7:0], service_time[15:8]
	input  wire logic                           s_axis_tuser,  // arrival
	input  wire logic                           m_axis_tvalid,
	input  wire logic                           m_axis_tready,
	input  wire logic [lwqd_pkg::M_TDATA_W-1:0] m_axis_tdata,  // see the core's port list
	output int                                  mismatches,
	output int                                  pending
);

	typedef struct packed {
		logic [lwqd_pkg::LINE_IDX_W-1:0]                     line;
		logic                                                dropped;
		logic [lwqd_pkg::LINE_COUNT-1:0]                     done;
		logic [lwqd_pkg::LINE_COUNT-1:0][lwqd_pkg::TAG_W-1:0] tag;
	} tick_outcome_t;

	// model of the three rings
	lwqd_pkg::job_t ring [lwqd_pkg::LINE_COUNT][LINE_DEPTH];
	int             head [lwqd_pkg::LINE_COUNT];
	int             fill [lwqd_pkg::LINE_COUNT];
	logic [11:0]    work [lwqd_pkg::LINE_COUNT];

	tick_outcome_t outcome_q[$];

	// place the arrival on the least-loaded line, then serve every head once
	task automatic dispatch_and_serve(input logic arrives,
			input logic [lwqd_pkg::TAG_W-1:0] tag,
			input logic [lwqd_pkg::SVC_W-1:0] svc, output tick_outcome_t res);
		int                          best;
		logic [lwqd_pkg::SVC_W-1:0]  need;
		begin
			res  = '0;
			need = (svc == '0) ? lwqd_pkg::SVC_W'(1) : svc;
			if (arrives) begin
				best = 0;
				for (int k = 1; k < lwqd_pkg::LINE_COUNT; k++) begin
					if (work[k] < work[best])
						best = k;
				end
				res.line = lwqd_pkg::LINE_IDX_W'(best + 1);
				if (fill[best] >= LINE_DEPTH) begin
					res.dropped = 1'b1;
				end else begin
					ring[best][(head[best] + fill[best]) % LINE_DEPTH].tag = tag;
					ring[best][(head[best] + fill[best]) % LINE_DEPTH].rem = need;
					fill[best]++;
					work[best] = work[best] + 12'(need);
				end
			end
			for (int k = 0; k < lwqd_pkg::LINE_COUNT; k++) begin
				if (fill[k] != 0) begin
					if (ring[k][head[k]].rem != '0)
						ring[k][head[k]].rem = ring[k][head[k]].rem - 1'b1;
					if (work[k] != '0)
						work[k] = work[k] - 1'b1;
					if (ring[k][head[k]].rem == '0) begin
						res.done[k] = 1'b1;
						res.tag[k]  = ring[k][head[k]].tag;
						head[k]     = (head[k] + 1) % LINE_DEPTH;
						fill[k]--;
					end
				end
			end
		end
	endtask

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		tick_outcome_t want;
		tick_outcome_t next;
		int            rec;
		if (!arst_n) begin
			for (int k = 0; k < lwqd_pkg::LINE_COUNT; k++) begin
				head[k] = 0;
				fill[k] = 0;
				work[k] = '0;
			end
			outcome_q.delete();
			mismatches = 0;
			pending    = 0;
		end else begin
			// results first: a tick taken at this edge cannot show up before the next one
			if (m_axis_tvalid && m_axis_tready) begin
				if (outcome_q.size() == 0) begin
					mismatches++;
					$display("%0t ns: result transfer with nothing expected, got %h",
						$time, m_axis_tdata);
				end else begin
					want = outcome_q.pop_front();
					check_field("assigned_line", 8'(want.line),
						8'(m_axis_tdata[lwqd_pkg::ASSIGN_POS +: lwqd_pkg::LINE_IDX_W]));
					check_field("arrival_dropped", 8'(want.dropped),
						8'(m_axis_tdata[lwqd_pkg::DROP_POS]));
					for (int k = 0; k < lwqd_pkg::LINE_COUNT; k++) begin
						rec = lwqd_pkg::LINE_REC_POS + k * lwqd_pkg::LINE_REC_W;
						check_field($sformatf("line%0d_done", k + 1), 8'(want.done[k]),
							8'(m_axis_tdata[rec]));
						check_field($sformatf("line%0d_tag", k + 1), want.tag[k],
							m_axis_tdata[rec + 1 +: lwqd_pkg::TAG_W]);
					end
					check_field("padding", 8'd0,
						8'(m_axis_tdata[lwqd_pkg::M_TDATA_W-1:lwqd_pkg::RES_W]));
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				dispatch_and_serve(s_axis_tuser, s_axis_tdata[lwqd_pkg::TAG_W-1:0],
					s_axis_tdata[lwqd_pkg::TAG_W +: lwqd_pkg::SVC_W], next);
				outcome_q.push_back(next);
			end
			pending = outcome_q.size();
		end
	end

endmodule

// ----- dv/least_work_queue_dispatcher_core_test.sv -----
// Top of the dispatcher testbench: clock, reset, tick stimulus and result back-pressure.
// Depends on lwqd_pkg, least_work_queue_dispatcher_core and lwqd_scoreboard.
`timescale 1ns / 1ps
module least_work_queue_dispatcher_core_test;

	localparam int DEPTH        = 16;
	localparam int IDLE_PCT     = 12;
	localparam int RANDOM_TICKS = 1900;
	localparam int CYCLE_LIMIT  = 150000;

	typedef enum int {LOAD_LIGHT, LOAD_MIXED, LOAD_FLOOD, LOAD_DRAIN} load_mix_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           s_axis_tvalid = 1'b0;
	logic                           s_axis_tready;
	logic [lwqd_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;  // job_tag[7:0], service_time[15:8]
	logic                           s_axis_tuser = 1'b0; // arrival
	logic                           m_axis_tvalid;
	logic                           m_axis_tready = 1'b0;
	logic [lwqd_pkg::M_TDATA_W-1:0] m_axis_tdata;
	logic                           steady = 1'b0;       // both sides stop idling while set
	int                             mismatches;
	int                             pending;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	least_work_queue_dispatcher_core #(.LINE_DEPTH(DEPTH)) u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	lwqd_scoreboard #(.LINE_DEPTH(DEPTH)) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.mismatches    (mismatches),
		.pending       (pending)
	);

	// result side stalls at random unless in the steady stretch
	always @(posedge clk)
		m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);

	// One tick transfer. tready only moves at rising edges, so it is sampled at
	// the falling edge and the transfer completes at the following rising edge.
	task automatic offer_tick(input logic arrives, input logic [lwqd_pkg::TAG_W-1:0] tag,
			input logic [lwqd_pkg::SVC_W-1:0] svc);
		while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= arrives;
		s_axis_tdata  <= {svc, tag};
		@(negedge clk);
		while (!s_axis_tready)
			@(negedge clk);
		@(posedge clk);
	endtask

	// hold off new ticks until every result is back
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	initial begin : watchdog
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("end of test: mismatches");
		$finish;
	end

	initial begin : stimulus
		load_mix_t                  mix;
		int                         sent;
		int                         span;
		logic                       arrives;
		logic [lwqd_pkg::SVC_W-1:0] svc;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, zero service, same-tick departure, ties
		offer_tick(1'b0, 8'h00, 8'h00);   // idle tick, empty lines
		offer_tick(1'b1, 8'hFF, 8'h00);   // zero service, leaves at once
		offer_tick(1'b1, 8'h00, 8'h01);   // single tick job
		offer_tick(1'b1, 8'hA5, 8'hFF);   // longest job on line 1
		offer_tick(1'b1, 8'h5A, 8'h03);
		offer_tick(1'b1, 8'h3C, 8'h03);
		offer_tick(1'b1, 8'h81, 8'h02);
		offer_tick(1'b0, 8'hFF, 8'hFF);   // no arrival, fields still toggle
		offer_tick(1'b1, 8'h7E, 8'h80);
		offer_tick(1'b1, 8'h01, 8'h7F);
		offer_tick(1'b0, 8'h55, 8'hAA);
		offer_tick(1'b1, 8'hC3, 8'h00);
		offer_tick(1'b1, 8'h24, 8'h02);
		offer_tick(1'b1, 8'h42, 8'h02);
		offer_tick(1'b0, 8'hAA, 8'h55);
		offer_tick(1'b0, 8'h00, 8'hFF);
		offer_tick(1'b1, 8'h99, 8'h01);
		offer_tick(1'b1, 8'h66, 8'h10);
		offer_tick(1'b1, 8'hE7, 8'h01);
		offer_tick(1'b0, 8'h18, 8'h00);

		// back-to-back medium jobs until all lines are full and arrivals drop
		for (int n = 0; n < 60; n++)
			offer_tick(1'b1, 8'($urandom_range(0, 255)), 8'($urandom_range(16, 40)));
		drain_results();

		sent = 0;
		while (sent < RANDOM_TICKS) begin
			mix  = load_mix_t'($urandom_range(0, 3));
			span = $urandom_range(20, 80);
			// one long stretch with no idling on either side
			steady <= (sent >= 700 && sent < 1000);
			if (sent >= 1200 && sent < 1280)
				drain_results();
			for (int n = 0; n < span; n++) begin
				case (mix)
					LOAD_LIGHT: begin
						arrives = ($urandom_range(0, 99) < 35);
						svc     = 8'($urandom_range(0, 6));
					end
					LOAD_MIXED: begin
						arrives = ($urandom_range(0, 99) < 60);
						svc     = 8'($urandom_range(0, 31));
					end
					LOAD_FLOOD: begin
						arrives = ($urandom_range(0, 99) < 95);
						svc     = 8'($urandom_range(8, 40));
					end
					default: begin
						arrives = ($urandom_range(0, 99) < 8);
						svc     = 8'($urandom_range(0, 255));
					end
				endcase
				if ($urandom_range(0, 99) < 5)
					svc = 8'($urandom_range(0, 255));
				offer_tick(arrives, 8'($urandom_range(0, 255)), svc);
				sent++;
			end
		end
		steady <= 1'b0;

		drain_results();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/core/lwqd_pkg.sv
rtl/core/lwqd_ram.sv
rtl/core/least_work_queue_dispatcher_core.sv
rtl/core/lwqd_checker.sv
dv/lwqd_checker.sv
dv/least_work_queue_dispatcher_core_test.sv
